// ----- sv/rtcm3_frame_parser_crc24q_core_assert.svh -----
// Assertion macros used by the checker file of the RTCM3 deframer.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef RTCM3_FRAME_PARSER_CRC24Q_CORE_ASSERT_SVH
`define RTCM3_FRAME_PARSER_CRC24Q_CORE_ASSERT_SVH

// Same-cycle implication.
`define RFP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");

// Next-cycle implication.
`define RFP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer assertion failed");

`endif

// ----- sv/rtcm3fp_pkg.sv -----
// Package for the RTCM3 deframer: phase type, frame constants and the CRC24Q byte update.
// Used by the core and by its checker; depends on nothing.
package rtcm3fp_pkg;

	localparam logic [7:0]  PREAMBLE = 8'hD3;
	localparam logic [24:0] CRC_POLY = 25'h1864CFB;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_PAYLOAD,
		PH_CRC0,
		PH_CRC1,
		PH_CRC2
	} phase_t;

	function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
		logic [23:0] c;
		c = crc ^ {b, 16'h0000};
		for (int i = 0; i < 8; i++) begin
			if (c[23]) begin
				c = {c[22:0], 1'b0} ^ CRC_POLY[23:0];
			end else begin
				c = {c[22:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- sv/rtcm3_frame_parser_crc24q_core.sv -----
// RTCM3 frame deframer with CRC24Q check, one byte per transaction.
// Depends on rtcm3fp_pkg for the phase type, constants and CRC update.
//
//   channel   direction   handshake               payload
//   in        sink        in_valid / in_stall     data_byte
//   out       source      out_valid / out_stall   frame_byte, marks, verdict fields
//   cfg       sink        cfg_we                  cfg_wdata (check_crc)
//
// Each byte passes an input register and a result register.
// One byte is taken every cycle while in_stall is low; the rate is set by the single CRC byte update per cycle.
// Reset returns the parser to preamble hunting with CRC checking disabled.
// A stall on the output holds the result; one more byte is buffered before in_stall rises.
module rtcm3_frame_parser_crc24q_core
	import rtcm3fp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  frame_byte,
	output logic        first_of_frame,
	output logic        last_of_frame,
	output logic [11:0] message_number,
	output logic [9:0]  payload_length,
	output logic        crc_good,
	output logic        frame_accepted
);

	logic        check_crc_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_free;
	logic        advance;

	phase_t      phase_q, phase_d;
	logic [9:0]  frame_len_q, frame_len_d;
	logic [9:0]  count_q, count_d;
	logic [23:0] crc_q, crc_d;
	logic [15:0] rcv_hi_q, rcv_hi_d;
	logic [11:0] msg_id_q, msg_id_d;

	logic        res_valid;
	logic        res_first;
	logic        res_last;
	logic [11:0] res_msg;
	logic [9:0]  res_len;
	logic        res_good;
	logic        res_accept;
	logic [23:0] crc_next;
	logic [9:0]  count_inc;
	logic        good;

	assign out_free = !out_valid || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_crc_q <= 1'b0;
		end else if (cfg_we) begin
			check_crc_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			frame_len_q <= '0;
			count_q     <= '0;
			crc_q       <= '0;
			rcv_hi_q    <= '0;
			msg_id_q    <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			frame_len_q <= frame_len_d;
			count_q     <= count_d;
			crc_q       <= crc_d;
			rcv_hi_q    <= rcv_hi_d;
			msg_id_q    <= msg_id_d;
		end
	end

	assign crc_next  = crc24q_byte(crc_q, byte_s1);
	assign count_inc = count_q + 10'd1;
	assign good      = ({rcv_hi_q, byte_s1} == crc_q);

	always_comb begin
		phase_d     = phase_q;
		frame_len_d = frame_len_q;
		count_d     = count_q;
		crc_d       = crc_q;
		rcv_hi_d    = rcv_hi_q;
		msg_id_d    = msg_id_q;
		res_valid   = 1'b1;
		res_first   = 1'b0;
		res_last    = 1'b0;
		res_msg     = '0;
		res_len     = '0;
		res_good    = 1'b0;
		res_accept  = 1'b0;
		unique case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == PREAMBLE) begin
					crc_d       = crc24q_byte(24'h000000, byte_s1);
					frame_len_d = '0;
					count_d     = '0;
					rcv_hi_d    = '0;
					msg_id_d    = '0;
					phase_d     = PH_LEN_HI;
					res_first   = 1'b1;
				end else begin
					res_valid = 1'b0;
				end
			end
			PH_LEN_HI: begin
				crc_d       = crc_next;
				frame_len_d = {byte_s1[1:0], 8'h00};
				phase_d     = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				crc_d       = crc_next;
				frame_len_d = {frame_len_q[9:8], byte_s1};
				count_d     = '0;
				phase_d     = ({frame_len_q[9:8], byte_s1} == 10'd0) ? PH_CRC0 : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				crc_d = crc_next;
				if (count_q == 10'd0) begin
					msg_id_d = {byte_s1, 4'h0};
				end else if (count_q == 10'd1) begin
					msg_id_d = {msg_id_q[11:4], byte_s1[7:4]};
				end
				count_d = count_inc;
				if (count_inc == frame_len_q) begin
					phase_d = PH_CRC0;
				end
			end
			PH_CRC0: begin
				rcv_hi_d = {byte_s1, 8'h00};
				phase_d  = PH_CRC1;
			end
			PH_CRC1: begin
				rcv_hi_d = {rcv_hi_q[15:8], byte_s1};
				phase_d  = PH_CRC2;
			end
			PH_CRC2: begin
				res_last   = 1'b1;
				res_msg    = (frame_len_q >= 10'd2) ? msg_id_q : 12'h000;
				res_len    = frame_len_q;
				res_good   = good;
				res_accept = good || !check_crc_q;
				phase_d    = PH_HUNT;
			end
			default: begin
				res_valid = 1'b0;
				phase_d   = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			frame_byte     <= byte_s1;
			first_of_frame <= res_first;
			last_of_frame  <= res_last;
			message_number <= res_msg;
			payload_length <= res_len;
			crc_good       <= res_good;
			frame_accepted <= res_accept;
		end
	end

endmodule

// ----- sv/rtcm3fp_checker.sv -----
// Port-level checker for the RTCM3 deframer core, attached by a bind statement.
// Depends on rtcm3fp_pkg and on the assertion macros in the shared header.
`include "rtcm3_frame_parser_crc24q_core_assert.svh"

module rtcm3fp_checker
	import rtcm3fp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  frame_byte,
	input logic        first_of_frame,
	input logic        last_of_frame,
	input logic [11:0] message_number,
	input logic [9:0]  payload_length,
	input logic        crc_good,
	input logic        frame_accepted
);

	`RFP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`RFP_ASSERT_IMPL(a_first_is_preamble, out_valid && first_of_frame, frame_byte == PREAMBLE && !last_of_frame)
	`RFP_ASSERT_IMPL(a_reject_only_bad_last, out_valid && !frame_accepted && last_of_frame, !crc_good)
	`RFP_ASSERT_IMPL(a_verdict_only_last, out_valid && !last_of_frame, message_number == 12'h000 && payload_length == 10'd0 && !crc_good && !frame_accepted)
	`RFP_ASSERT_IMPL(a_good_is_accepted, out_valid && last_of_frame && crc_good, frame_accepted)

endmodule

bind rtcm3_frame_parser_crc24q_core rtcm3fp_checker u_checker (.*);

// ----- tb/rtcm3fp_echo_scoreboard_pkg.sv -----
// Scoreboard for the RTCM3 deframer testbench: a byte-level frame predictor and echo checker.
// Depends on rtcm3fp_pkg for the phase type and the preamble value.
package rtcm3fp_echo_scoreboard_pkg;
	import rtcm3fp_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic [7:0]  frame_byte;
		logic        first_of_frame;
		logic        last_of_frame;
		logic [11:0] message_number;
		logic [9:0]  payload_length;
		logic        crc_good;
		logic        frame_accepted;
	} echo_t;

	localparam logic [23:0] CRC24Q_GEN = 24'h864CFB;

	function automatic logic [23:0] crc24q_shift(input logic [23:0] crc, input logic [7:0] b);
		logic [23:0] r;
		logic        fb;
		r = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[23] ^ b[i];
			r = {r[22:0], 1'b0};
			if (fb) begin
				r = r ^ CRC24Q_GEN;
			end
		end
		return r;
	endfunction

	class frame_scoreboard;
		phase_t      state;
		logic        reject_bad;
		logic [9:0]  frame_len;
		logic [9:0]  count;
		logic [23:0] crc_calc;
		logic [23:0] crc_rx;
		logic [11:0] msg_id;
		echo_t       expected_echoes[$];
		int          errors;

		function new();
			state = PH_HUNT;
			reject_bad = 1'b0;
			frame_len = '0;
			count = '0;
			crc_calc = '0;
			crc_rx = '0;
			msg_id = '0;
			errors = 0;
		endfunction

		function void set_check(input logic v);
			reject_bad = v;
		endfunction

		function int pending_echoes();
			return expected_echoes.size();
		endfunction

		function void predict_echo(input logic [7:0] b);
			echo_t e;
			e = '0;
			e.frame_byte = b;
			case (state)
			PH_HUNT: begin
				if (b != PREAMBLE) begin
					return;
				end
				crc_calc = crc24q_shift(24'h0, b);
				frame_len = '0;
				count = '0;
				crc_rx = '0;
				msg_id = '0;
				e.first_of_frame = 1'b1;
				state = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				crc_calc = crc24q_shift(crc_calc, b);
				frame_len = {b[1:0], 8'h00};
				state = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				crc_calc = crc24q_shift(crc_calc, b);
				frame_len[7:0] = b;
				count = '0;
				state = (frame_len == 0) ? PH_CRC0 : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				crc_calc = crc24q_shift(crc_calc, b);
				if (count == 0) begin
					msg_id = {b, 4'h0};
				end else if (count == 1) begin
					msg_id[3:0] = b[7:4];
				end
				count = count + 10'd1;
				if (count == frame_len) begin
					state = PH_CRC0;
				end
			end
			PH_CRC0: begin
				crc_rx = {b, 16'h0000};
				state = PH_CRC1;
			end
			PH_CRC1: begin
				crc_rx[15:8] = b;
				state = PH_CRC2;
			end
			PH_CRC2: begin
				crc_rx[7:0] = b;
				e.last_of_frame = 1'b1;
				e.message_number = (frame_len >= 2) ? msg_id : 12'h000;
				e.payload_length = frame_len;
				e.crc_good = (crc_rx == crc_calc);
				e.frame_accepted = e.crc_good || !reject_bad;
				state = PH_HUNT;
			end
			default: begin
				state = PH_HUNT;
				return;
			end
			endcase
			expected_echoes.push_back(e);
		endfunction

		function void compare_field(input string name, input logic [11:0] want,
				input logic [11:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= 100) begin
					$error("%s expected %0h actual %0h", name, want, got);
				end
			end
		endfunction

		function void check_echo(input echo_t got);
			echo_t want;
			if (expected_echoes.size() == 0) begin
				errors++;
				if (errors <= 100) begin
					$error("unexpected transaction, frame_byte %0h", got.frame_byte);
				end
				return;
			end
			want = expected_echoes.pop_front();
			compare_field("frame_byte", want.frame_byte, got.frame_byte);
			compare_field("first_of_frame", want.first_of_frame, got.first_of_frame);
			compare_field("last_of_frame", want.last_of_frame, got.last_of_frame);
			compare_field("message_number", want.message_number, got.message_number);
			compare_field("payload_length", want.payload_length, got.payload_length);
			compare_field("crc_good", want.crc_good, got.crc_good);
			compare_field("frame_accepted", want.frame_accepted, got.frame_accepted);
		endfunction
	endclass

endpackage

// ----- tb/tb_rtcm3_frame_parser_crc24q_core.sv -----
// Top-level testbench for rtcm3_frame_parser_crc24q_core: directed and random RTCM3 byte traffic.
// Depends on rtcm3fp_pkg and on the echo scoreboard in rtcm3fp_echo_scoreboard_pkg.
module tb_rtcm3_frame_parser_crc24q_core;
	timeunit 1ns;
	timeprecision 1ps;
	import rtcm3fp_pkg::*;
	import rtcm3fp_echo_scoreboard_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  frame_byte;
	logic        first_of_frame;
	logic        last_of_frame;
	logic [11:0] message_number;
	logic [9:0]  payload_length;
	logic        crc_good;
	logic        frame_accepted;

	frame_scoreboard echo_board = new();
	int unsigned     send_idle_pct = 0;
	int unsigned     recv_stall_pct = 0;
	int unsigned     frame_bytes_sent = 0;
	int              quiet_cycles = 0;

	always #6 clk = ~clk;

	rtcm3_frame_parser_crc24q_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_byte    (frame_byte),
		.first_of_frame(first_of_frame),
		.last_of_frame (last_of_frame),
		.message_number(message_number),
		.payload_length(payload_length),
		.crc_good      (crc_good),
		.frame_accepted(frame_accepted)
	);

	always @(posedge clk) begin
		echo_t got;
		if (out_valid && !out_stall) begin
			got = {frame_byte, first_of_frame, last_of_frame, message_number,
				payload_length, crc_good, frame_accepted};
			echo_board.check_echo(got);
		end
		out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic byte_q_t random_payload(input int unsigned len);
		byte_q_t p;
		repeat (len) p.push_back(8'($urandom_range(255, 0)));
		return p;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		echo_board.predict_echo(b);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (echo_board.pending_echoes() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_check(input logic v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		echo_board.set_check(v);
	endtask

	task automatic send_frame(input byte_q_t payload, input logic [5:0] reserved,
			input bit corrupt);
		byte_q_t     frame;
		logic [23:0] crc;
		logic [9:0]  len;
		int unsigned pos;
		len = 10'(payload.size());
		frame.push_back(PREAMBLE);
		frame.push_back({reserved, len[9:8]});
		frame.push_back(len[7:0]);
		foreach (payload[i]) frame.push_back(payload[i]);
		crc = '0;
		foreach (frame[i]) crc = crc24q_shift(crc, frame[i]);
		frame.push_back(crc[23:16]);
		frame.push_back(crc[15:8]);
		frame.push_back(crc[7:0]);
		if (corrupt) begin
			pos = $urandom_range(frame.size() - 1, 3);
			frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(7, 0));
		end
		foreach (frame[i]) push_byte(frame[i]);
		frame_bytes_sent += frame.size();
	endtask

	task automatic run_traffic(input int unsigned budget);
		int unsigned start;
		int unsigned pick;
		int unsigned len;
		logic [7:0]  nb;
		start = frame_bytes_sent;
		while (frame_bytes_sent - start < budget) begin
			pick = $urandom_range(99, 0);
			if (pick < 12) begin
				repeat ($urandom_range(6, 1)) begin
					nb = 8'($urandom_range(255, 0));
					if (nb == PREAMBLE) begin
						nb = ~nb;
					end
					push_byte(nb);
				end
			end else begin
				len = ($urandom_range(99, 0) < 15) ? $urandom_range(2, 0)
					: $urandom_range(20, 0);
				send_frame(random_payload(len), 6'($urandom_range(63, 0)), pick < 28);
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_check(1'b1);
		push_byte(8'h00);
		push_byte(8'hFF);
		send_frame(random_payload(0), 6'h3F, 1'b0);
		send_frame('{8'hA5}, 6'h00, 1'b1);
		send_frame('{8'hFF, 8'hF0, 8'hD3}, 6'h15, 1'b0);
		push_byte(8'h7F);
		write_check(1'b0);
		send_frame('{8'h00}, 6'h2A, 1'b1);

		write_check(1'b1);
		send_idle_pct = 8;
		recv_stall_pct = 71;
		run_traffic(200);
		wait_idle();
		run_traffic(40);

		write_check(1'b0);
		send_idle_pct = 71;
		recv_stall_pct = 8;
		send_frame(random_payload(1023), 6'($urandom_range(63, 0)), 1'b1);
		run_traffic(100);

		write_check(1'b1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_traffic(200);

		wait_idle();
		if (echo_board.errors == 0 && echo_board.pending_echoes() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
